FILE: rtl/sis_pkg.sv
// Package for the sorted index set: list sizes, stream field widths, operation
// and status codes, and the control bundle that the top level hands to each list cell.
// No dependencies.
package sis_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int INDEX_BITS  = 10;
   localparam int POS_BITS    = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

   localparam int KIND_W       = 2;
   localparam int POSITION_W   = 4;
   localparam int VAR_INDEX_W  = 10;
   localparam int COUNT_W      = 5;
   localparam int STATUS_W     = 2;
   localparam int READ_VALUE_W = 10;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 24;
   localparam int CMP_BITS     = (CNT_BITS > POSITION_W) ? CNT_BITS : POSITION_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPLACE = 2'd0,
      KIND_DELETE  = 2'd1,
      KIND_ADD     = 2'd2,
      KIND_READ    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef logic [INDEX_BITS-1:0] sis_entry_type;

   typedef struct packed {
      logic write;
      logic insert;
      logic shift;
      logic live;
   } sis_cell_ctrl_type;

endpackage

FILE: rtl/sis_cell.sv
// One cell of the sorted list: holds one entry and computes its next value
// from its neighbors for a combined remove-and-insert.
// Depends on sis_pkg.
module sis_cell
   import sis_pkg::*;
(
   input  logic              clock,
   input  sis_cell_ctrl_type ctrl,
   input  sis_entry_type     ins_value,
   input  sis_entry_type     left_shift,
   input  logic              left_lt,
   input  sis_entry_type     right_entry,
   output sis_entry_type     entry,
   output sis_entry_type     shift_out,
   output logic              lt_out
);

   sis_entry_type entry_ff;
   sis_entry_type entry_in;
   sis_entry_type shifted;
   logic          lt;

   always_comb begin
      shifted = ctrl.shift ? right_entry : entry_ff;
      lt      = ctrl.live && (shifted < ins_value);
      if (!ctrl.insert || lt) begin
         entry_in = shifted;
      end else if (left_lt) begin
         entry_in = ins_value;
      end else begin
         entry_in = left_shift;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         entry_ff <= entry_in;
      end
   end

   assign entry     = entry_ff;
   assign shift_out = shifted;
   assign lt_out    = lt;

endmodule

FILE: rtl/sorted_index_set.sv
// Top level of the sorted index set: stream ports, operation decode, the row
// of list cells and the result register.
// Depends on sis_pkg and sis_cell.
//
// The block keeps an ascending list of up to MAX_ENTRIES indices and answers
// each request transfer (replace, delete, add or read) with exactly one
// response transfer carrying the new length, a status and the read value.
// Operations need no sequencing: all cells compare their entry
// with the new value at once and take their next entry from themselves or a
// neighbor, so the response appears the cycle after the request is taken and
// one request per cycle is accepted while the response side keeps up. The
// response register lets a new request in whenever the waiting response is
// taken in the same cycle. No clearing pass follows reset; the length alone
// marks which entries are valid.
module sorted_index_set
   import sis_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0: position (4), var_index (10), zero fill.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: kind (2).
   input  logic [KIND_W-1:0]      req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: count (5), status (2), read_value (10), zero fill.
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   kind_type                req_kind;
   logic [POSITION_W-1:0]   req_position;
   logic [VAR_INDEX_W-1:0]  req_var_index;
   logic                    accept;
   logic                    in_range;
   logic                    full;
   logic [POS_BITS-1:0]     sel_pos;
   sis_entry_type           ins_value;

   logic                    do_insert;
   logic                    do_remove;
   logic [CNT_BITS-1:0]     base_len;
   status_type              status_in;
   logic [READ_VALUE_W-1:0] read_value_in;

   logic [CNT_BITS-1:0]     length_ff;
   logic [CNT_BITS-1:0]     length_in;
   logic                    rsp_tvalid_ff;
   logic [COUNT_W-1:0]      count_ff;
   status_type              status_ff;
   logic [READ_VALUE_W-1:0] read_value_ff;

   sis_entry_type           entry_w [MAX_ENTRIES];
   sis_entry_type           shift_w [MAX_ENTRIES];
   logic                    lt_w    [MAX_ENTRIES];

   assign req_kind      = kind_type'(req_tuser);
   assign req_position  = req_tdata[POSITION_W-1:0];
   assign req_var_index = req_tdata[POSITION_W +: VAR_INDEX_W];
   assign req_tready    = !rsp_tvalid_ff || rsp_tready;
   assign accept        = req_tvalid && req_tready;
   assign in_range      = CMP_BITS'(req_position) < CMP_BITS'(length_ff);
   assign full          = length_ff == CNT_BITS'(MAX_ENTRIES);
   assign sel_pos       = POS_BITS'(req_position);
   assign ins_value     = INDEX_BITS'(req_var_index);

   always_comb begin
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      base_len      = length_ff;
      length_in     = length_ff;
      status_in     = STATUS_OK;
      read_value_in = '0;
      unique case (req_kind)
         KIND_ADD: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               do_insert = 1'b1;
               length_in = length_ff + CNT_BITS'(1);
            end
         end
         KIND_REPLACE: begin
            if (!in_range) begin
               status_in = STATUS_RANGE;
            end else begin
               do_remove = 1'b1;
               do_insert = 1'b1;
               base_len  = length_ff - CNT_BITS'(1);
            end
         end
         KIND_DELETE: begin
            if (!in_range) begin
               status_in = STATUS_RANGE;
            end else begin
               do_remove = 1'b1;
               length_in = length_ff - CNT_BITS'(1);
            end
         end
         KIND_READ: begin
            if (!in_range) begin
               status_in = STATUS_RANGE;
            end else begin
               read_value_in = READ_VALUE_W'(entry_w[sel_pos]);
            end
         end
         default: begin
            status_in = STATUS_RANGE;
         end
      endcase
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      sis_cell_ctrl_type ctrl;
      sis_entry_type     left_shift;
      logic              left_lt;
      sis_entry_type     right_entry;

      assign ctrl.write  = accept && (do_insert || do_remove);
      assign ctrl.insert = do_insert;
      assign ctrl.shift  = do_remove && (POS_BITS'(i) >= sel_pos);
      assign ctrl.live   = CNT_BITS'(i) < base_len;

      if (i == 0) begin : g_left_edge
         assign left_shift = '0;
         assign left_lt    = 1'b1;
      end else begin : g_left
         assign left_shift = shift_w[i-1];
         assign left_lt    = lt_w[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_right_edge
         assign right_entry = '0;
      end else begin : g_right
         assign right_entry = entry_w[i+1];
      end

      sis_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .ins_value   (ins_value),
         .left_shift  (left_shift),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .shift_out   (shift_w[i]),
         .lt_out      (lt_w[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            rsp_tvalid_ff <= req_tvalid;
         end
         if (accept) begin
            length_ff <= length_in;
         end
      end
      if (accept) begin
         count_ff      <= COUNT_W'(length_in);
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - READ_VALUE_W - STATUS_W - COUNT_W)'(0),
                        read_value_ff, status_ff, count_ff};

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("list length beyond capacity");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_kind == KIND_ADD) && !full
      |=> length_ff == $past(length_ff) + CNT_BITS'(1))
      else $error("accepted add did not grow the list");

   a_refused_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (status_ff != STATUS_OK) |-> read_value_ff == '0)
      else $error("refused operation returned a read value");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      length_ff >= CNT_BITS'(2) |-> entry_w[0] <= entry_w[1])
      else $error("list head out of order");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for sorted_index_set: drives request transfers,
// predicts every response with an internal list model and compares them.
// Depends on sis_pkg and the sorted_index_set RTL.
`timescale 1ns / 1ps

module testbench;
   import sis_pkg::*;

   typedef struct {
      logic [COUNT_W-1:0]      count;
      logic [STATUS_W-1:0]     status;
      logic [READ_VALUE_W-1:0] read_value;
   } list_answer_type;

   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 533;
   localparam int MAX_PRINTS   = 100;

   class sorted_set_tracker;
      sis_entry_type   entries [MAX_ENTRIES];
      int              length;
      list_answer_type answers [$];
      int              errors;

      function new();
         length = 0;
         errors = 0;
         foreach (entries[i]) entries[i] = '0;
      endfunction

      task report(string what);
         if (errors < MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
         errors++;
      endtask

      function void swap_entries(int a, int b);
         sis_entry_type t;
         t = entries[a];
         entries[a] = entries[b];
         entries[b] = t;
      endfunction

      function void apply_request(kind_type kind, logic [POSITION_W-1:0] pos,
                                  logic [VAR_INDEX_W-1:0] val);
         list_answer_type ans;
         sis_entry_type   v;
         int              at;
         int              j;
         v = val[INDEX_BITS-1:0];
         ans.status = STATUS_OK;
         ans.read_value = '0;
         if (kind == KIND_ADD) begin
            if (length >= MAX_ENTRIES) begin
               ans.status = STATUS_FULL;
            end else begin
               at = 0;
               while (at < length && entries[at] < v) at++;
               for (j = length; j > at; j--) entries[j] = entries[j-1];
               entries[at] = v;
               length++;
            end
         end else if (int'(pos) >= length) begin
            ans.status = STATUS_RANGE;
         end else if (kind == KIND_REPLACE) begin
            entries[pos] = v;
            for (j = 0; j + 1 < length; j++)
               if (entries[j] > entries[j+1]) swap_entries(j, j + 1);
            for (j = length; j > 1; j--)
               if (entries[j-1] < entries[j-2]) swap_entries(j - 1, j - 2);
         end else if (kind == KIND_DELETE) begin
            length--;
            for (j = pos; j < length; j++) entries[j] = entries[j+1];
         end else begin
            ans.read_value = READ_VALUE_W'(entries[pos]);
         end
         ans.count = COUNT_W'(length);
         answers.push_back(ans);
      endfunction

      task check_answer(logic [RSP_TDATA_W-1:0] data);
         list_answer_type exp;
         logic [COUNT_W-1:0]      count;
         logic [STATUS_W-1:0]     status;
         logic [READ_VALUE_W-1:0] read_value;
         count = data[COUNT_W-1:0];
         status = data[COUNT_W +: STATUS_W];
         read_value = data[COUNT_W+STATUS_W +: READ_VALUE_W];
         if (answers.size() == 0) begin
            report($sformatf("response transfer with no request waiting, data %h", data));
         end else begin
            exp = answers.pop_front();
            if (count !== exp.count)
               report($sformatf("count %0d, expected %0d", count, exp.count));
            if (status !== exp.status)
               report($sformatf("status %0d, expected %0d", status, exp.status));
            if (read_value !== exp.read_value)
               report($sformatf("read_value %0d, expected %0d", read_value,
                                exp.read_value));
         end
      endtask

      function int pending();
         return answers.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]      req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   sorted_set_tracker tracker;
   int                send_idle;
   int                recv_idle;
   int                phase;
   bit                hold_done;
   int                quiet_cycles;

   sorted_index_set u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_answer(rsp_tdata);
         if (req_tvalid && req_tready)
            tracker.apply_request(kind_type'(req_tuser), req_tdata[POSITION_W-1:0],
                                  req_tdata[POSITION_W +: VAR_INDEX_W]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase == 2 && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task send_request(kind_type kind, logic [POSITION_W-1:0] pos,
                     logic [VAR_INDEX_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= REQ_TDATA_W'({val, pos});
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task run_directed();
      logic [VAR_INDEX_W-1:0] fill [16];
      fill = '{10'd1023, 10'd0, 10'd512, 10'd512, 10'd1, 10'd1022, 10'd341, 10'd682,
               10'd0, 10'd1023, 10'd5, 10'd5, 10'd200, 10'd800, 10'd100, 10'd900};
      send_request(KIND_READ, 4'd15, 10'd0);
      send_request(KIND_DELETE, 4'd0, 10'd0);
      send_request(KIND_REPLACE, 4'd3, 10'd77);
      foreach (fill[i]) send_request(KIND_ADD, 4'(i), fill[i]);
      send_request(KIND_ADD, 4'd0, 10'd7);
      send_request(KIND_READ, 4'd15, 10'd0);
      send_request(KIND_REPLACE, 4'd15, 10'd0);
      send_request(KIND_REPLACE, 4'd0, 10'd1023);
      send_request(KIND_DELETE, 4'd15, 10'd0);
      send_request(KIND_DELETE, 4'd0, 10'd0);
      send_request(KIND_READ, 4'd14, 10'd0);
   endtask

   task run_random(int n);
      int                     add_pct;
      int                     del_pct;
      int                     r;
      int                     len;
      kind_type               kind;
      logic [POSITION_W-1:0]  pos;
      logic [VAR_INDEX_W-1:0] val;
      add_pct = 40;
      del_pct = 30;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            add_pct = $urandom_range(70, 10);
            del_pct = $urandom_range(50, 10);
         end
         len = tracker.length;
         r = $urandom_range(99);
         if (r < add_pct) kind = KIND_ADD;
         else if (r < add_pct + del_pct) kind = KIND_DELETE;
         else if ($urandom_range(1) == 0) kind = KIND_REPLACE;
         else kind = KIND_READ;
         if (len > 0 && $urandom_range(9) < 8) pos = POSITION_W'($urandom_range(len - 1, 0));
         else pos = POSITION_W'($urandom_range(15));
         case ($urandom_range(3))
            0: val = VAR_INDEX_W'($urandom_range(15));
            1: val = ($urandom_range(1) == 0) ? '0 : '1;
            2: val = VAR_INDEX_W'(1) << $urandom_range(VAR_INDEX_W - 1);
            default: val = VAR_INDEX_W'($urandom);
         endcase
         send_request(kind, pos, val);
      end
   endtask

   initial begin
      tracker = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      phase = 0;
      send_idle = 37;
      recv_idle = 72;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(PHASE_ITEMS);
      send_idle = 72;
      recv_idle = 37;
      phase = 1;
      run_random(PHASE_ITEMS);
      send_idle = 0;
      recv_idle = 0;
      phase = 2;
      run_random(PHASE_ITEMS);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/sorted_index_set.sv
test/testbench.sv
